/* src/rfv_pkg.sv */
// ----------------------------------------------------------------------------
// rfv_pkg: shared types and constants of the random-forest vote classifier
// Field widths of the item and result beats, operation codes, node record
// layout and default sizes of the node and feature stores.
// ----------------------------------------------------------------------------
package rfv_pkg;

    // Default sizes
    localparam int MAX_TREES_DEF      = 64;
    localparam int NODES_PER_TREE_DEF = 1024;
    localparam int NUM_FEATURES_DEF   = 64;

    // Fixed field widths
    localparam int OP_W     = 2;
    localparam int TIDX_W   = 6;
    localparam int NIDX_W   = 10;
    localparam int FIDX_W   = 6;
    localparam int VAL_W    = 32;
    localparam int TCFG_W   = 7;
    localparam int MARGIN_OUT_W = 8;

    // Item operations
    typedef enum logic [OP_W-1:0] {
        OP_WRITE_NODE    = 2'd0,
        OP_WRITE_FEATURE = 2'd1,
        OP_CLASSIFY      = 2'd2
    } t_op;

    // One stored tree node
    typedef struct packed {
        logic                    leaf;
        logic                    cls;
        logic [FIDX_W-1:0]       feat;
        logic signed [VAL_W-1:0] thr;
        logic [NIDX_W-1:0]       left;
        logic [NIDX_W-1:0]       right;
    } t_node;

endpackage

/* src/rfv_if.sv */
// ----------------------------------------------------------------------------
// rfv_if: handshake channels of the random-forest vote classifier
// Item channel, result channel and tree-count configuration channel, each
// with valid, ready and its payload.
// ----------------------------------------------------------------------------
interface rfv_item_if import rfv_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         operation;
    logic [TIDX_W-1:0]       tree_index;
    logic [NIDX_W-1:0]       node_index;
    logic                    node_is_leaf;
    logic [FIDX_W-1:0]       node_feature;
    logic signed [VAL_W-1:0] node_threshold;
    logic [NIDX_W-1:0]       node_left;
    logic [NIDX_W-1:0]       node_right;
    logic                    leaf_class;
    logic [FIDX_W-1:0]       feature_index;
    logic signed [VAL_W-1:0] feature_value;

    modport source (
        output valid, operation, tree_index, node_index, node_is_leaf, node_feature,
               node_threshold, node_left, node_right, leaf_class, feature_index,
               feature_value,
        input  ready
    );
    modport sink (
        input  valid, operation, tree_index, node_index, node_is_leaf, node_feature,
               node_threshold, node_left, node_right, leaf_class, feature_index,
               feature_value,
        output ready
    );
endinterface

interface rfv_result_if import rfv_pkg::*; ();
    logic                           valid;
    logic                           ready;
    logic                           predicted_label;
    logic signed [MARGIN_OUT_W-1:0] vote_margin;
    logic                           walk_error;

    modport source (output valid, predicted_label, vote_margin, walk_error, input ready);
    modport sink   (input valid, predicted_label, vote_margin, walk_error, output ready);
endinterface

interface rfv_cfg_if import rfv_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [TCFG_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

/* src/random_forest_vote_classifier.sv */
// ----------------------------------------------------------------------------
// random_forest_vote_classifier: binary random forest with majority vote
// Loads tree nodes and sample features into on-chip memories and walks the
// trees in use one node at a time, summing +1/-1 leaf votes into a margin.
// ----------------------------------------------------------------------------
//  channel    | dir | beat contents
//  -----------+-----+----------------------------------------------------------
//  i_item     | in  | operation, node write fields, feature write fields
//  o_result   | out | predicted_label, vote_margin, walk_error
//  i_cfg      | in  | data = trees_in_use (always ready)
//
//  Node and feature writes are taken while idle. A classify beat walks each
//  tree in use through the single read port of the node store, each inner node
//  followed by the feature store read. The result then waits in the output
//  register; new writes are accepted while it waits, a new classify finishes
//  only once the register is free.
//  Reset clears control state only; both memories are undefined until written.
// ----------------------------------------------------------------------------
module random_forest_vote_classifier import rfv_pkg::*; #(
    parameter int MAX_TREES      = MAX_TREES_DEF,
    parameter int NODES_PER_TREE = NODES_PER_TREE_DEF,
    parameter int NUM_FEATURES   = NUM_FEATURES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rfv_item_if.sink      i_item,
    rfv_result_if.source  o_result,
    rfv_cfg_if.sink       i_cfg
);

    localparam int TREE_W     = (MAX_TREES > 1) ? $clog2(MAX_TREES) : 1;
    localparam int NODE_W     = $clog2(NODES_PER_TREE);
    localparam int FEAT_W     = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
    localparam int CNT_W      = $clog2(MAX_TREES + 1);
    localparam int MARGIN_W   = $clog2(MAX_TREES + 1) + 1;
    localparam int ADDR_W     = TREE_W + NODE_W;
    localparam int NODE_DEPTH = 2 ** ADDR_W;
    localparam int FEAT_DEPTH = 2 ** FEAT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_NODE,
        S_FEAT,
        S_DONE
    } t_state;

    // Memories and their read data
    t_node                   r_node_mem [NODE_DEPTH];
    logic signed [VAL_W-1:0] r_feat_mem [FEAT_DEPTH];
    t_node                   r_node_q;
    logic signed [VAL_W-1:0] r_feat_q;

    // Control and result registers
    t_state                         r_state,      n_state;
    logic [TCFG_W-1:0]              r_trees;
    logic [CNT_W-1:0]               r_count,      n_count;
    logic [TREE_W-1:0]              r_tree,       n_tree;
    logic [NODE_W-1:0]              r_visits,     n_visits;
    logic signed [MARGIN_W-1:0]     r_margin,     n_margin;
    logic                           r_err,        n_err;
    logic                           r_feat_ok,    n_feat_ok;
    logic                           r_out_valid,  n_out_valid;
    logic                           r_out_label,  n_out_label;
    logic signed [MARGIN_OUT_W-1:0] r_out_margin, n_out_margin;
    logic                           r_out_err,    n_out_err;

    // Memory access strobes
    logic              node_rd_en;
    logic [ADDR_W-1:0] node_rd_addr;
    logic              node_wr_en;
    logic [ADDR_W-1:0] node_wr_addr;
    logic              feat_rd_en;
    logic [FEAT_W-1:0] feat_rd_addr;
    logic              feat_wr_en;
    logic [FEAT_W-1:0] feat_wr_addr;

    // Walk helpers
    logic                    item_fire;
    logic                    last_tree;
    logic signed [VAL_W-1:0] feat_x;
    logic [NIDX_W-1:0]       child;
    t_node                   wr_node;

    assign item_fire = i_item.valid && i_item.ready;
    assign last_tree = (CNT_W'(r_tree) + CNT_W'(1)) == r_count;
    assign feat_x    = r_feat_ok ? r_feat_q : '0;
    assign child     = (feat_x < r_node_q.thr) ? r_node_q.left : r_node_q.right;

    assign wr_node.leaf  = i_item.node_is_leaf;
    assign wr_node.cls   = i_item.leaf_class;
    assign wr_node.feat  = i_item.node_feature;
    assign wr_node.thr   = i_item.node_threshold;
    assign wr_node.left  = i_item.node_left;
    assign wr_node.right = i_item.node_right;

    assign node_wr_addr = {TREE_W'(i_item.tree_index), NODE_W'(i_item.node_index)};
    assign feat_wr_addr = FEAT_W'(i_item.feature_index);

    assign i_item.ready            = (r_state == S_IDLE);
    assign i_cfg.ready             = 1'b1;
    assign o_result.valid          = r_out_valid;
    assign o_result.predicted_label = r_out_label;
    assign o_result.vote_margin    = r_out_margin;
    assign o_result.walk_error     = r_out_err;

    // Decode beats and sequence the tree walks
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_tree       = r_tree;
        n_visits     = r_visits;
        n_margin     = r_margin;
        n_err        = r_err;
        n_feat_ok    = r_feat_ok;
        n_out_valid  = r_out_valid;
        n_out_label  = r_out_label;
        n_out_margin = r_out_margin;
        n_out_err    = r_out_err;
        node_rd_en   = 1'b0;
        node_rd_addr = '0;
        node_wr_en   = 1'b0;
        feat_rd_en   = 1'b0;
        feat_rd_addr = FEAT_W'(r_node_q.feat);
        feat_wr_en   = 1'b0;

        // Drop a result once taken
        if (o_result.valid && o_result.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (item_fire) begin
                    case (t_op'(i_item.operation))
                        OP_WRITE_NODE: begin
                            node_wr_en = (32'(i_item.tree_index) < 32'(MAX_TREES)) &&
                                         (32'(i_item.node_index) < 32'(NODES_PER_TREE));
                        end
                        OP_WRITE_FEATURE: begin
                            feat_wr_en = 32'(i_item.feature_index) < 32'(NUM_FEATURES);
                        end
                        OP_CLASSIFY: begin
                            n_count  = (32'(r_trees) > 32'(MAX_TREES)) ?
                                       CNT_W'(MAX_TREES) : CNT_W'(r_trees);
                            n_tree   = '0;
                            n_visits = '0;
                            n_margin = '0;
                            n_err    = 1'b0;
                            if (n_count == '0) begin
                                n_state = S_DONE;
                            end else begin
                                node_rd_en = 1'b1;
                                n_state    = S_NODE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_NODE: begin
                if (r_node_q.leaf) begin
                    // Vote and advance to the next tree
                    n_margin = r_node_q.cls ? r_margin + MARGIN_W'(1) :
                                              r_margin - MARGIN_W'(1);
                    if (last_tree) begin
                        n_state = S_DONE;
                    end else begin
                        n_tree       = r_tree + TREE_W'(1);
                        n_visits     = '0;
                        node_rd_en   = 1'b1;
                        node_rd_addr = {n_tree, NODE_W'(0)};
                    end
                end else begin
                    // Fetch the split feature
                    feat_rd_en = 1'b1;
                    n_feat_ok  = 32'(r_node_q.feat) < 32'(NUM_FEATURES);
                    n_state    = S_FEAT;
                end
            end

            S_FEAT: begin
                if ((32'(child) >= 32'(NODES_PER_TREE)) ||
                    (r_visits == NODE_W'(NODES_PER_TREE - 1))) begin
                    // Abandon this walk with no vote
                    n_err = 1'b1;
                    if (last_tree) begin
                        n_state = S_DONE;
                    end else begin
                        n_tree       = r_tree + TREE_W'(1);
                        n_visits     = '0;
                        node_rd_en   = 1'b1;
                        node_rd_addr = {n_tree, NODE_W'(0)};
                        n_state      = S_NODE;
                    end
                end else begin
                    n_visits     = r_visits + NODE_W'(1);
                    node_rd_en   = 1'b1;
                    node_rd_addr = {r_tree, NODE_W'(child)};
                    n_state      = S_NODE;
                end
            end

            S_DONE: begin
                // Hold until the output register is free
                if (!r_out_valid || o_result.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_label  = !r_margin[MARGIN_W-1] && (r_margin != '0);
                    n_out_margin = MARGIN_OUT_W'(r_margin);
                    n_out_err    = r_err;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_trees     <= TCFG_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                r_trees <= i_cfg.data;
            end
        end
        r_count      <= n_count;
        r_tree       <= n_tree;
        r_visits     <= n_visits;
        r_margin     <= n_margin;
        r_err        <= n_err;
        r_feat_ok    <= n_feat_ok;
        r_out_label  <= n_out_label;
        r_out_margin <= n_out_margin;
        r_out_err    <= n_out_err;
    end

    // Node store: one write or one read per cycle
    always_ff @(posedge i_clk) begin
        if (node_wr_en) begin
            r_node_mem[node_wr_addr] <= wr_node;
        end
        if (node_rd_en) begin
            r_node_q <= r_node_mem[node_rd_addr];
        end
    end

    // Feature store
    always_ff @(posedge i_clk) begin
        if (feat_wr_en) begin
            r_feat_mem[feat_wr_addr] <= i_item.feature_value;
        end
        if (feat_rd_en) begin
            r_feat_q <= r_feat_mem[feat_rd_addr];
        end
    end

endmodule
